// File: sv/signed_int_to_radix_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to text converter
// Clocked assertion shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_ASCII_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sira_pkg.sv
// ----------------------------------------------------------------------------
// sira_pkg
// Shared types, character codes and the digit-to-character lookup.
// ----------------------------------------------------------------------------
package sira_pkg;

  localparam int RADIX_BITS    = 6;
  localparam int DIGIT_BITS    = 6;
  localparam int CHAR_BITS     = 7;
  localparam int DIV_STEP_BITS = 8;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;

  localparam logic [DIGIT_BITS-1:0] DIGIT_MAX   = 6'd35;
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2d;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_SHOW
  } sira_state_e;

  // Digits above the largest legal one read as 'z'.
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [DIGIT_BITS-1:0] s;
    logic [CHAR_BITS-1:0]  c;
    s = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (s < DIGIT_TEN) begin
      c = CHAR_ZERO + {1'b0, s};
    end else begin
      c = CHAR_LOWER_A + {1'b0, s - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

// File: sv/sira_in_if.sv
// ----------------------------------------------------------------------------
// sira_in_if
// Input channel: one signed integer per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sira_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: sv/sira_out_if.sv
// ----------------------------------------------------------------------------
// sira_out_if
// Output channel: one ASCII character per item with an end-of-text flag.
// ----------------------------------------------------------------------------
interface sira_out_if;
  logic                            valid;
  logic                            ready;
  logic [sira_pkg::CHAR_BITS-1:0]  char_code;
  logic                            last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: sv/sira_divider.sv
// ----------------------------------------------------------------------------
// sira_divider
// Iterative unsigned divider by a small radix, several quotient bits a cycle.
// ----------------------------------------------------------------------------
module sira_divider #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [VALUE_BITS-1:0]               dividend_i,
  input  logic [sira_pkg::RADIX_BITS-1:0]     divisor_i,
  output logic                                done_o,
  output logic [VALUE_BITS-1:0]               quotient_o,
  output logic [sira_pkg::DIGIT_BITS-1:0]     remainder_o
);

  localparam int StepBits = sira_pkg::DIV_STEP_BITS;
  localparam int Steps    = (VALUE_BITS + StepBits - 1) / StepBits;
  localparam int PadBits  = Steps * StepBits;
  localparam int CntW     = $clog2(Steps + 1);
  localparam int DigW     = sira_pkg::DIGIT_BITS;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PadBits-1:0]    work_q, work_d;
  logic [DigW-1:0]       rem_q, rem_d;
  logic [DigW-1:0]       divisor_q;

  logic [StepBits-1:0]   qbits;
  logic [DigW-1:0]       step_rem;

  // Long division on the top slice of the working word, most significant
  // bit first; the partial remainder never reaches the divisor.
  always_comb begin
    logic [DigW:0]   r;
    logic [DigW:0]   div_ext;
    r       = {1'b0, rem_q};
    div_ext = {1'b0, divisor_q};
    qbits   = '0;
    for (int i = 0; i < StepBits; i++) begin
      r = {r[DigW-1:0], work_q[PadBits-1-i]};
      if (r >= div_ext) begin
        r = r - div_ext;
        qbits[StepBits-1-i] = 1'b1;
      end
    end
    step_rem = r[DigW-1:0];
  end

  always_comb begin
    logic [PadBits+StepBits-1:0] shifted;
    shifted = {work_q, qbits};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    work_d  = work_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      work_d = PadBits'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      work_d = shifted[PadBits-1:0];
      rem_d  = step_rem;
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

// File: sv/signed_int_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii
// Converts a signed integer to ASCII text in a programmable radix.
// ----------------------------------------------------------------------------
// The input channel takes one signed integer per item; the output channel
// returns its text one character per item, most significant digit first,
// with a leading '-' for negative values and last_char set on the final one.
// The radix register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the block is idle; the block itself does not enforce
// this. Values below 2 act as 2 and values above 36 act as 36. Digits come
// from a shared divider that resolves eight quotient bits a cycle. Each
// character is then read from the digit memory and presented; a minus sign,
// if any, is presented first.
// Only one item is in flight: in_i.ready is high only when idle.
// A stalled receiver simply holds the current character; no state is lost.
// Reset returns the sequencer to idle and the radix to ten; the digit memory
// needs no clearing since every entry read was written by the same item.
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_ascii_assert.svh"

module signed_int_to_radix_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sira_in_if.sink                          in_i,
  sira_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [sira_pkg::RADIX_BITS-1:0]  cfg_wdata_i
);

  localparam int CntW = $clog2(VALUE_BITS + 1);
  localparam int IdxW = $clog2(VALUE_BITS);
  localparam int DigW = sira_pkg::DIGIT_BITS;

  sira_pkg::sira_state_e             state_q, state_d;
  logic [sira_pkg::RADIX_BITS-1:0]   radix_q;
  logic [sira_pkg::RADIX_BITS-1:0]   radix_eff;
  logic                              neg_q, neg_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;

  logic [DigW-1:0]                   digit_mem [VALUE_BITS];
  logic [DigW-1:0]                   rd_data_q;
  logic [IdxW-1:0]                   rd_addr;
  logic [IdxW-1:0]                   wr_addr;
  logic                              mem_we;

  logic                              div_start;
  logic [VALUE_BITS-1:0]             div_dividend;
  logic                              div_done;
  logic [VALUE_BITS-1:0]             div_quot;
  logic [DigW-1:0]                   div_rem;

  logic [VALUE_BITS-1:0]             in_bits;
  logic [VALUE_BITS-1:0]             magnitude;
  logic                              in_fire;
  logic                              out_fire;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= sira_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  assign radix_eff = (radix_q < sira_pkg::RADIX_MIN) ? sira_pkg::RADIX_MIN :
                     (radix_q > sira_pkg::RADIX_MAX) ? sira_pkg::RADIX_MAX : radix_q;

  // Two's complement negation in the value width is exact even for the most
  // negative value, whose magnitude is the sign bit alone.
  assign in_bits   = in_i.value;
  assign magnitude = in_bits[VALUE_BITS-1] ? (~in_bits + VALUE_BITS'(1)) : in_bits;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_o.valid && out_o.ready;

  assign div_dividend = (state_q == sira_pkg::ST_IDLE) ? magnitude : div_quot;

  sira_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (radix_eff),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Sequencer: divide down to zero, then replay the digits in reverse.
  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    div_start = 1'b0;
    mem_we    = 1'b0;
    case (state_q)
      sira_pkg::ST_IDLE: begin
        if (in_fire) begin
          neg_d     = in_bits[VALUE_BITS-1];
          cnt_d     = '0;
          div_start = 1'b1;
          state_d   = sira_pkg::ST_DIV;
        end
      end
      sira_pkg::ST_DIV: begin
        if (div_done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
          if (div_quot == '0) begin
            state_d = neg_q ? sira_pkg::ST_SIGN : sira_pkg::ST_FETCH;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      sira_pkg::ST_SIGN: begin
        if (out_fire) begin
          state_d = sira_pkg::ST_FETCH;
        end
      end
      sira_pkg::ST_FETCH: begin
        state_d = sira_pkg::ST_SHOW;
      end
      sira_pkg::ST_SHOW: begin
        if (out_fire) begin
          cnt_d = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = sira_pkg::ST_IDLE;
          end else begin
            state_d = sira_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_d = sira_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sira_pkg::ST_IDLE;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
    end
  end

  // Digit memory: least significant digit at address zero.
  assign wr_addr = cnt_q[IdxW-1:0];
  assign rd_addr = IdxW'(cnt_q - CntW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[wr_addr] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= digit_mem[rd_addr];
  end

  assign in_i.ready      = (state_q == sira_pkg::ST_IDLE);
  assign out_o.valid     = (state_q == sira_pkg::ST_SIGN) || (state_q == sira_pkg::ST_SHOW);
  assign out_o.char_code = (state_q == sira_pkg::ST_SIGN) ? sira_pkg::CHAR_MINUS :
                           sira_pkg::digit_char(rd_data_q);
  assign out_o.last_char = (state_q == sira_pkg::ST_SHOW) && (cnt_q == CntW'(1));

  // Checks
  `SIRA_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, in_i.ready, !out_o.valid,
                    "input accepted while a character is still pending")
  `SIRA_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, out_fire && out_o.last_char, in_i.ready,
                    "block not ready after the final character of an item")
  `SIRA_ASSERT_SAME(a_digits_held, clk_i, rst_ni,
                    (state_q == sira_pkg::ST_SIGN) || (state_q == sira_pkg::ST_SHOW),
                    cnt_q != '0, "emitting with no stored digits")

endmodule

// File: test/sira_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sira_text_checker
// Watches the channels of the integer-to-text converter and predicts and
// checks every character it returns.
// ----------------------------------------------------------------------------
module sira_text_checker #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [VALUE_BITS-1:0]           in_value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [sira_pkg::CHAR_BITS-1:0]  char_code_i,
  input  logic                            last_char_i,
  input  logic                            cfg_we_i,
  input  logic [sira_pkg::RADIX_BITS-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              chars_checked_o
);

  typedef struct packed {
    logic [sira_pkg::CHAR_BITS-1:0] code;
    logic                           last;
  } text_char_t;

  localparam string DIGIT_GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";

  logic [sira_pkg::RADIX_BITS-1:0] radix_setting = sira_pkg::RADIX_RESET;
  text_char_t                      expected_chars[$];
  int                              n_fail    = 0;
  int                              n_checked = 0;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    chars_checked_o = 0;
  end

  // Builds the text of one value: digits by repeated division of the
  // magnitude, least significant first, then queued in reverse order.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0]           mag;
    logic [VALUE_BITS-1:0]           base;
    logic [VALUE_BITS-1:0]           rem;
    logic [sira_pkg::DIGIT_BITS-1:0] digits[$];
    byte                             glyph;
    if (radix_setting < sira_pkg::RADIX_MIN) begin
      base = VALUE_BITS'(sira_pkg::RADIX_MIN);
    end else if (radix_setting > sira_pkg::RADIX_MAX) begin
      base = VALUE_BITS'(sira_pkg::RADIX_MAX);
    end else begin
      base = VALUE_BITS'(radix_setting);
    end
    // The unsigned negation also gives the right magnitude for the most
    // negative value.
    mag = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
    do begin
      rem = mag % base;
      digits.push_back(rem[sira_pkg::DIGIT_BITS-1:0]);
      mag = mag / base;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) begin
      expected_chars.push_back('{sira_pkg::CHAR_MINUS, 1'b0});
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      glyph = DIGIT_GLYPHS[digits[k]];
      expected_chars.push_back('{glyph[sira_pkg::CHAR_BITS-1:0], (k == 0)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      radix_setting = sira_pkg::RADIX_RESET;
      expected_chars.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        radix_setting = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        predict_text(in_value_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("char_code: no character expected, got 0x%02h", char_code_i);
          n_fail++;
        end else begin
          want = expected_chars.pop_front();
          n_checked++;
          if (char_code_i !== want.code) begin
            $error("char_code: expected 0x%02h, actual 0x%02h", want.code, char_code_i);
            n_fail++;
          end
          if (last_char_i !== want.last) begin
            $error("last_char: expected %0b, actual %0b", want.last, last_char_i);
            n_fail++;
          end
        end
      end
      pending_o       <= expected_chars.size();
      fail_count_o    <= n_fail;
      chars_checked_o <= n_checked;
    end
  end

endmodule

// File: test/tb_signed_int_to_radix_ascii.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_radix_ascii
// Drives integers and radix settings into the converter and gives the
// verdict; the checker beside the block predicts and compares the text.
// ----------------------------------------------------------------------------
module tb_signed_int_to_radix_ascii;

  localparam int VALUE_BITS = 32;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [sira_pkg::RADIX_BITS-1:0] cfg_wdata = '0;

  int                    sender_idle_pct   = 0;
  int                    receiver_idle_pct = 0;
  int                    base_now          = 10;
  int                    items_sent        = 0;
  int                    fail_count;
  int                    pending;
  int                    chars_checked;

  sira_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  sira_out_if                           out_ch ();

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
  end

  signed_int_to_radix_ascii #(
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  sira_text_checker #(
    .VALUE_BITS (VALUE_BITS)
  ) text_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .in_value_i      (in_ch.value),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .char_code_i     (out_ch.char_code),
    .last_char_i     (out_ch.last_char),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .chars_checked_o (chars_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Holds the sender back until every queued character has come out.
  task automatic drain_text();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_radix(input logic [sira_pkg::RADIX_BITS-1:0] r);
    drain_text();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_now = (r < sira_pkg::RADIX_MIN) ? sira_pkg::RADIX_MIN :
               (r > sira_pkg::RADIX_MAX) ? sira_pkg::RADIX_MAX : r;
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] p;
    p = 1;
    case ($urandom_range(5))
      0: v = $urandom_range(0, 40);
      1: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
      2: begin
        case ($urandom_range(3))
          0: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          1: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          2: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
          default: v = '0;
        endcase
      end
      3: begin
        // Values next to a power of the radix change the digit count.
        repeat ($urandom_range(0, VALUE_BITS - 1)) begin
          if (p <= (32'h7fff_ffff / base_now)) p = p * base_now;
        end
        v = p - $urandom_range(0, 1);
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  initial begin
    logic [sira_pkg::RADIX_BITS-1:0] radix_plan[10];
    logic [VALUE_BITS-1:0]           directed[12];
    logic [31:0]                     pick;
    radix_plan = '{6'd16, 6'd0, 6'd36, 6'd63, 6'd2, 6'd37, 6'd7, 6'd1, 6'd10, 6'd0};
    pick = $urandom_range(0, 63);
    radix_plan[9] = pick[sira_pkg::RADIX_BITS-1:0];
    directed = '{32'd0, 32'd1, -32'sd1, 32'h7fff_ffff, 32'h8000_0000, 32'd9, 32'd10,
                 -32'sd10, 32'd35, 32'd36, 32'd1_000_000_000, -32'sd1_999_999_999};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct   = 21;
    receiver_idle_pct = 80;
    // Radix left at its reset value of ten for the directed values.
    foreach (directed[i]) send_value(directed[i]);

    foreach (radix_plan[ph]) begin
      if (ph == 3) begin
        sender_idle_pct   = 80;
        receiver_idle_pct = 21;
      end else if (ph == 6) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      set_radix(radix_plan[ph]);
      send_value(32'h8000_0000);
      send_value(32'h7fff_ffff);
      repeat (20) send_value(random_value());
    end

    drain_text();
    $display("Converted %0d integers into %0d characters under 11 radix settings,",
             items_sent, chars_checked);
    $display("including the saturating settings 0, 1, 37 and 63, with varied stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
